>>> design/edd_pkg.sv
`timescale 1ns / 1ps
package edd_pkg;

  // Storage and field widths
  localparam int MaxWidth   = 2048;
  localparam int IdxW       = $clog2(MaxWidth);
  localparam int GreyW      = 8;
  localparam int ByteW      = 8;
  localparam int CfgWidthW  = 12;
  localparam int CfgHeightW = 16;
  localparam int CfgDataW   = 16;
  localparam int CfgIdxW    = 1;
  localparam int ErrW       = 18;

  // Fixed point: 255 * 256 is 1.0
  localparam int FixOne  = 65280;
  localparam int FixHalf = 32640;

  // Queue between front and back
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgImageWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgImageHeight = 1'b1;

  // Classified pixel, front to back
  typedef struct packed {
    logic [GreyW-1:0] grey;
    logic [IdxW-1:0]  x;
    logic             first_col;
    logic             last_col;
    logic             row_gt0;
    logic             frame_end;
  } item_t;

  // Queue head toward the back
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

endpackage

>>> design/edd_if.sv
`timescale 1ns / 1ps
interface edd_pix_if;
  logic                        valid;
  logic                        ready;
  logic [edd_pkg::GreyW-1:0]   grey_level;

  modport source (output valid, output grey_level, input ready);
  modport sink   (input valid, input grey_level, output ready);
endinterface

interface edd_byte_if;
  logic                        valid;
  logic                        ready;
  logic [edd_pkg::ByteW-1:0]   bitmap_byte;

  modport source (output valid, output bitmap_byte, input ready);
  modport sink   (input valid, input bitmap_byte, output ready);
endinterface

>>> design/edd_front.sv
`timescale 1ns / 1ps
module edd_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [edd_pkg::CfgWidthW-1:0]     image_width_i,
  input  logic [edd_pkg::CfgHeightW-1:0]    image_height_i,
  edd_pix_if.sink                           pix_i,
  input  logic                              q_full_i,
  output logic                              push_o,
  output edd_pkg::item_t                    item_o
);
  import edd_pkg::*;

  logic [IdxW-1:0]       col_q, col_d;
  logic [CfgHeightW-1:0] row_q, row_d;
  logic [IdxW-1:0]       w_last;
  logic [CfgHeightW-1:0] h_last;
  logic [IdxW-1:0]       x;
  logic                  last_col;
  logic                  frame_end;

  // effective last column / last row after clamping
  always_comb begin
    if (image_width_i == '0) begin
      w_last = '0;
    end else if (32'(image_width_i) > MaxWidth) begin
      w_last = IdxW'(MaxWidth - 1);
    end else begin
      w_last = IdxW'(32'(image_width_i) - 32'd1);
    end
    h_last = (image_height_i == '0) ? '0 : image_height_i - 1'b1;
  end

  assign x         = (col_q > w_last) ? w_last : col_q;
  assign last_col  = (x == w_last);
  assign frame_end = last_col && (row_q >= h_last);

  assign pix_i.ready = !q_full_i;
  assign push_o      = pix_i.valid && !q_full_i;

  always_comb begin
    item_o.grey      = pix_i.grey_level;
    item_o.x         = x;
    item_o.first_col = (x == '0);
    item_o.last_col  = last_col;
    item_o.row_gt0   = (row_q != '0);
    item_o.frame_end = frame_end;
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (push_o) begin
      col_d = last_col ? '0 : x + 1'b1;
      if (last_col) begin
        row_d = frame_end ? '0 : row_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

>>> design/edd_queue.sv
`timescale 1ns / 1ps
module edd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  edd_pkg::item_t   item_i,
  output logic             full_o,
  input  logic             pop_i,
  output edd_pkg::q_head_t head_o
);
  import edd_pkg::*;

  item_t            slot_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_pop;

  assign full_o       = (cnt_q == QCntW'(QueueDepth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = slot_q[rd_ptr_q];
  assign do_pop       = pop_i && head_o.valid;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> design/edd_back.sv
`timescale 1ns / 1ps
module edd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  edd_pkg::q_head_t head_i,
  output logic             pop_o,
  edd_byte_if.source       byte_o
);
  import edd_pkg::*;

  localparam logic [2:0] K7 = 3'd7;
  localparam logic [2:0] K5 = 3'd5;
  localparam logic [2:0] K3 = 3'd3;
  localparam logic [2:0] K1 = 3'd1;

  // floor(e * k / 16)
  function automatic logic signed [ErrW-1:0] share(input logic signed [ErrW-1:0] e,
                                                   input logic [2:0] k);
    logic signed [ErrW+3:0] p;
    p = $signed({{4{e[ErrW-1]}}, e}) * $signed({{(ErrW+1){1'b0}}, k});
    return p[ErrW+3:4];
  endfunction

  // next-row error line
  logic signed [ErrW-1:0] mem [MaxWidth];

  logic                   ex_valid_q;
  item_t                  ex_q;
  logic signed [ErrW-1:0] rd_q;
  logic                   fwd_hit_q;
  logic signed [ErrW-1:0] fwd_q;

  // last column entry held aside (single write port), copied into the
  // line whenever the port is free
  logic                   lr_valid_q;
  logic [IdxW-1:0]        lr_addr_q;
  logic signed [ErrW-1:0] lr_data_q;

  logic signed [ErrW-1:0] carry_q;
  logic signed [ErrW-1:0] bps0_q, bps1_q;
  logic [ByteW-1:0]       pack_q;
  logic [2:0]             bits_q;
  logic                   out_valid_q;
  logic [ByteW-1:0]       out_byte_q;

  logic                   emit, retire;
  logic signed [ErrW-1:0] stored;
  logic signed [19:0]     acc;
  logic [16:0]            acc_c;
  logic                   dark;
  logic signed [ErrW-1:0] err;
  logic signed [ErrW-1:0] s7, s5, s3, s1;
  logic signed [ErrW-1:0] below_left, b0;
  logic                   we;
  logic [IdxW-1:0]        wa;
  logic                   mem_we;
  logic [IdxW-1:0]        mem_wa;
  logic signed [ErrW-1:0] mem_wd;
  logic [ByteW-1:0]       pack_d;

  assign emit   = (bits_q == 3'd7);
  assign retire = ex_valid_q && (!emit || !out_valid_q || byte_o.ready);
  assign pop_o  = head_i.valid && (!ex_valid_q || retire);

  always_comb begin
    if (!ex_q.row_gt0) begin
      stored = '0;
    end else if (lr_valid_q && lr_addr_q == ex_q.x) begin
      stored = lr_data_q;
    end else if (fwd_hit_q) begin
      stored = fwd_q;
    end else begin
      stored = rd_q;
    end
  end

  always_comb begin
    acc = $signed({4'b0, ex_q.grey, 8'b0})
        + $signed({{2{carry_q[ErrW-1]}}, carry_q})
        + $signed({{2{stored[ErrW-1]}}, stored});
    if (acc[19]) begin
      acc_c = '0;
    end else if (acc[18:0] > 19'(FixOne)) begin
      acc_c = 17'(FixOne);
    end else begin
      acc_c = acc[16:0];
    end
    dark = (acc_c < 17'(FixHalf));
    err  = dark ? $signed({1'b0, acc_c}) : $signed({1'b0, acc_c}) - ErrW'(FixOne);
  end

  assign s7         = share(err, K7);
  assign s5         = share(err, K5);
  assign s3         = share(err, K3);
  assign s1         = share(err, K1);
  assign below_left = bps0_q + s3;
  assign b0         = bps1_q + s5;
  assign we         = retire && !ex_q.first_col;
  assign wa         = ex_q.x - 1'b1;
  assign pack_d     = pack_q | (ByteW'(dark) << bits_q);

  // below-left share has the port; otherwise the held last column entry
  assign mem_we = we || lr_valid_q;
  assign mem_wa = we ? wa : lr_addr_q;
  assign mem_wd = we ? below_left : lr_data_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (pop_o) begin
      rd_q <= mem[head_i.item.x];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ex_q      <= head_i.item;
      fwd_hit_q <= we && (wa == head_i.item.x);
      fwd_q     <= below_left;
    end
    if (retire && ex_q.last_col) begin
      lr_addr_q <= ex_q.x;
      lr_data_q <= b0;
    end
    if (retire && emit) begin
      out_byte_q <= pack_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q  <= 1'b0;
      lr_valid_q  <= 1'b0;
      carry_q     <= '0;
      bps0_q      <= '0;
      bps1_q      <= '0;
      pack_q      <= '0;
      bits_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        ex_valid_q <= 1'b1;
      end else if (retire) begin
        ex_valid_q <= 1'b0;
      end
      if (retire) begin
        if (ex_q.last_col) begin
          lr_valid_q <= 1'b1;
          carry_q    <= '0;
          bps0_q     <= '0;
          bps1_q     <= '0;
        end else begin
          if (we && wa == lr_addr_q) begin
            lr_valid_q <= 1'b0;
          end
          carry_q <= s7;
          bps0_q  <= b0;
          bps1_q  <= s1;
        end
        if (emit || ex_q.frame_end) begin
          pack_q <= '0;
          bits_q <= '0;
        end else begin
          pack_q <= pack_d;
          bits_q <= bits_q + 1'b1;
        end
      end
      if (retire && emit) begin
        out_valid_q <= 1'b1;
      end else if (byte_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign byte_o.valid       = out_valid_q;
  assign byte_o.bitmap_byte = out_byte_q;

endmodule

>>> design/error_diffusion_dither_1bpp.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake            Payload
// pix_i     in   valid/ready          grey_level  [7:0]  raster order, 255 white
// byte_o    out  valid/ready          bitmap_byte [7:0]  bit0 leftmost, 1 dark
// cfg       in   cfg_we_i, no ready   cfg_idx_i / cfg_data_i [15:0]
//
// One pixel per clock while the output takes bytes; a byte passes the queue,
// the back stage register and the output register after its eighth pixel.
// The rate is set by the carry loop in the back stage (clip, threshold and the
// 7/16 share are combinational) and by the single write port of the error line memory.
// Reset clears counters, carries and packing at once; the error line memory
// has no clearing pass, the first row of a frame never reads it.
// A byte held at the output stalls the back stage only when its next byte is
// due; the two-entry queue lets the front keep accepting meanwhile.
module error_diffusion_dither_1bpp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [edd_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [edd_pkg::CfgDataW-1:0]    cfg_data_i,
  edd_pix_if.sink                         pix_i,
  edd_byte_if.source                      byte_o
);
  import edd_pkg::*;

  logic [CfgWidthW-1:0]  image_width_q;
  logic [CfgHeightW-1:0] image_height_q;

  logic    push;
  item_t   push_item;
  logic    q_full;
  logic    pop;
  q_head_t head;

  // config registers; the user writes them only while idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= CfgWidthW'(640);
      image_height_q <= CfgHeightW'(480);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgImageWidth:  image_width_q  <= cfg_data_i[CfgWidthW-1:0];
        CfgImageHeight: image_height_q <= cfg_data_i[CfgHeightW-1:0];
        default: ;
      endcase
    end
  end

  // front: position tracking and classification
  edd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .image_width_i  (image_width_q),
    .image_height_i (image_height_q),
    .pix_i          (pix_i),
    .q_full_i       (q_full),
    .push_o         (push),
    .item_o         (push_item)
  );

  // short queue decoupling the two halves
  edd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .full_o (q_full),
    .pop_i  (pop),
    .head_o (head)
  );

  // back: error diffusion, error line memory, packing, output register
  edd_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .byte_o (byte_o)
  );

endmodule

>>> tb/tb_error_diffusion_dither_1bpp.sv
`timescale 1ns / 1ps
module tb_error_diffusion_dither_1bpp;
  import edd_pkg::*;

  // Generous ceiling: ~1350 pixels with worst sender gaps, output stalls,
  // the long receiver hold and a drain pause per phase fit many times over.
  localparam int CycleLimit     = 200000;
  localparam int RandomItems    = 1300;
  // Bytes pass the queue, back stage and output registers after their eighth pixel;
  // pixels that finish no byte may still sit in the two-entry queue, so give the block some slack.
  localparam int DrainCycles    = 16;
  localparam int LongHoldCycles = 300;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  edd_pix_if  pix_if ();
  edd_byte_if byte_if ();

  error_diffusion_dither_1bpp i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix_i      (pix_if),
    .byte_o     (byte_if)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Dither predictor: own copy of the geometry and of the diffusion state
  // ---------------------------------------------------------------------------
  logic [CfgWidthW-1:0]   shadow_width  = CfgWidthW'(640);
  logic [CfgHeightW-1:0]  shadow_height = CfgHeightW'(480);

  logic signed [ErrW-1:0] line_err [MaxWidth];  // error owed to the next row
  bit                     line_written [MaxWidth];
  int                     right_carry = 0;      // 7/16 share for the next pixel
  int                     below_cur   = 0;      // partial sum for column x-1
  int                     below_nxt   = 0;      // 1/16 share seeding column x
  int                     col_pos     = 0;
  int                     row_pos     = 0;
  logic [ByteW-1:0]       pack_bits   = '0;
  int                     pack_cnt    = 0;

  logic [ByteW-1:0]       bytes_due [$];        // bitmap bytes still to arrive
  logic [GreyW-1:0]       pixels_to_send [$];

  int failures = 0;

  // floor(err * weight / 16); arithmetic shift rounds toward minus infinity
  function automatic int floor_share(int err, int weight);
    return (err * weight) >>> 4;
  endfunction

  function automatic void dither_pixel(logic [GreyW-1:0] grey);
    int w, h, x, acc, err, b0;
    bit dark, row_end;
    // width 0 acts as 1, anything past the line store as its full size
    w = (shadow_width == 0) ? 1 : ((shadow_width > MaxWidth) ? MaxWidth : int'(shadow_width));
    h = (shadow_height == 0) ? 1 : int'(shadow_height);
    // a column beyond a narrowed width is taken as the last column
    x = (col_pos > w - 1) ? w - 1 : col_pos;
    row_end = (x == w - 1);

    acc = int'(grey) * 256 + right_carry;
    if (row_pos > 0) acc += int'(line_err[x]);
    if (acc < 0) acc = 0;
    if (acc > FixOne) acc = FixOne;
    dark = (acc < FixHalf);
    err  = dark ? acc : acc - FixOne;

    // below-left share closes the entry of the previous column
    if (x > 0) begin
      line_err[x - 1]     = ErrW'(below_cur + floor_share(err, 3));
      line_written[x - 1] = 1'b1;
    end
    b0 = below_nxt + floor_share(err, 5);

    if (row_end) begin
      // right and below-right shares fall off the edge
      line_err[x]     = ErrW'(b0);
      line_written[x] = 1'b1;
      right_carry = 0;
      below_cur   = 0;
      below_nxt   = 0;
      col_pos     = 0;
    end else begin
      right_carry = floor_share(err, 7);
      below_cur   = b0;
      below_nxt   = floor_share(err, 1);
      col_pos     = x + 1;
    end

    // LSB-first packing, runs on across rows
    pack_bits[pack_cnt] = dark;
    pack_cnt++;
    if (pack_cnt == 8) begin
      bytes_due.push_back(pack_bits);
      pack_bits = '0;
      pack_cnt  = 0;
    end

    // frame end drops a partial byte
    if (row_end) begin
      if (row_pos >= h - 1) begin
        row_pos   = 0;
        pack_bits = '0;
        pack_cnt  = 0;
      end else begin
        row_pos++;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: checks bytes against the predictor, feeds accepted pixels to it
  // ---------------------------------------------------------------------------
  bit pix_fired = 1'b0;  // pixel taken at the last rising edge

  always @(posedge clk_i) begin : byte_check
    logic [ByteW-1:0] want;
    if (rst_ni) begin
      // check first: a byte can never stem from a pixel taken at this edge
      if (byte_if.valid && byte_if.ready) begin
        if (bytes_due.size() == 0) begin
          $error("bitmap_byte: expected none, actual %02h", byte_if.bitmap_byte);
          failures++;
        end else begin
          want = bytes_due.pop_front();
          if (byte_if.bitmap_byte !== want) begin
            $error("bitmap_byte: expected %02h, actual %02h", want, byte_if.bitmap_byte);
            failures++;
          end
        end
      end
      pix_fired = pix_if.valid && pix_if.ready;
      if (pix_fired) dither_pixel(pix_if.grey_level);
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel driver: pops the pending queue, random gaps between items
  // ---------------------------------------------------------------------------
  bit idle_on  = 1'b1;
  int send_gap = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pix_if.valid <= 1'b0;
    end else if (!pix_if.valid || pix_fired) begin
      if (send_gap > 0) begin
        pix_if.valid <= 1'b0;
        send_gap--;
      end else if (pixels_to_send.size() > 0) begin
        pix_if.valid      <= 1'b1;
        pix_if.grey_level <= pixels_to_send.pop_front();
        if (idle_on && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 19);
      end else begin
        pix_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Byte receiver: random stalls, plus one long hold-off so the block backs
  // up into its input while the driver keeps offering pixels
  // ---------------------------------------------------------------------------
  bit long_hold_armed = 1'b0;
  bit long_hold_done  = 1'b0;
  int hold_left       = 0;
  int recv_gap        = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      byte_if.ready <= 1'b0;
    end else if (long_hold_armed && !long_hold_done) begin
      long_hold_done = 1'b1;
      hold_left      = LongHoldCycles;
      byte_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      byte_if.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      byte_if.ready <= 1'b0;
    end else begin
      byte_if.ready <= 1'b1;
      if (idle_on && $urandom_range(0, 9) == 0) recv_gap = $urandom_range(1, 19);
    end
  end

  // ---------------------------------------------------------------------------
  // Run guard
  // ---------------------------------------------------------------------------
  int cycle_count = 0;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Register write; only called while the block is idle, so the predictor's
  // copy may change right away.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int value);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CfgDataW'(value);
    if (idx == CfgImageWidth) shadow_width = CfgWidthW'(value);
    else                      shadow_height = CfgHeightW'(value);
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Wait until every queued pixel is in and every predicted byte is out.
  // Checked at the rising edge, where the driver's outputs are settled.
  task automatic drain_block();
    do @(posedge clk_i);
    while (pixels_to_send.size() != 0 || pix_if.valid || bytes_due.size() != 0);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int total, phase, n, style, level, w_raw, h_raw, w_eff, ok_prefix;
    logic [GreyW-1:0] g;

    cfg_we            = 1'b0;
    cfg_idx           = CfgImageWidth;
    cfg_data          = '0;
    pix_if.valid      = 1'b0;
    pix_if.grey_level = '0;
    byte_if.ready     = 1'b0;
    rst_ni            = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Height 0 acts as 1: every 8-pixel row is a frame, and the byte that
    // completes on the frame's last pixel must still come out.
    write_reg(CfgImageWidth, 8);
    write_reg(CfgImageHeight, 0);
    pixels_to_send = {8'd0, 8'd255, 8'd127, 8'd128, 8'd1, 8'd254, 8'd0, 8'd255};
    drain_block();

    // Width 0 acts as 1: a single column, error only flows straight down
    write_reg(CfgImageWidth, 0);
    write_reg(CfgImageHeight, 8);
    pixels_to_send = {8'd128, 8'd128, 8'd64, 8'd192, 8'd255, 8'd0, 8'd127, 8'd129};
    drain_block();

    // Oversized width clamps to the line store; then narrow it mid-row (the
    // sixth pixel lands past the new last column and closes the row), and
    // cut the height mid-frame so row 2 ends the frame. Twelve pixels: one
    // byte, the last four bits dropped at frame end.
    write_reg(CfgImageWidth, 4095);
    write_reg(CfgImageHeight, 5);
    pixels_to_send = {8'd255, 8'd0, 8'd200, 8'd50, 8'd128};
    drain_block();
    write_reg(CfgImageWidth, 3);
    pixels_to_send = {8'd100, 8'd30, 8'd230, 8'd128};
    drain_block();
    write_reg(CfgImageHeight, 2);
    pixels_to_send = {8'd0, 8'd255, 8'd127};
    drain_block();

    // Random phases: new geometry between phases, often mid-frame
    total = 0;
    phase = 0;
    while (total < RandomItems) begin
      // no idling over the last fifth, and some quiet phases before that
      idle_on = (total < RandomItems * 4 / 5) && ($urandom_range(0, 3) != 0);

      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 9))
          0:       w_raw = 0;
          1:       w_raw = MaxWidth;
          2:       w_raw = $urandom_range(MaxWidth + 1, 4095);
          3:       w_raw = 1;
          default: w_raw = $urandom_range(2, 24);
        endcase
        w_eff = (w_raw == 0) ? 1 : ((w_raw > MaxWidth) ? MaxWidth : w_raw);
        // Widening mid-frame must not reach line store entries that were
        // never written; cap it at the written prefix.
        if (row_pos > 0) begin
          ok_prefix = 0;
          while (ok_prefix < MaxWidth && line_written[ok_prefix]) ok_prefix++;
          if (w_eff > ok_prefix) w_raw = ok_prefix;
        end
        write_reg(CfgImageWidth, w_raw);
      end

      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 7))
          0:       h_raw = 0;
          1:       h_raw = 65535;
          2:       h_raw = $urandom_range(7, 65534);
          default: h_raw = $urandom_range(1, 6);
        endcase
        write_reg(CfgImageHeight, h_raw);
      end

      n     = $urandom_range(16, 96);
      style = $urandom_range(0, 3);
      level = $urandom_range(0, 255);
      if (phase == 4) n = 250;  // long phase for the receiver hold-off
      repeat (n) begin
        case (style)
          0:       g = GreyW'($urandom_range(0, 255));
          1:       g = GreyW'(level);                          // flat field
          2:       g = $urandom_range(0, 1) ? 8'd255 : 8'd0;   // hard edges
          default: g = GreyW'($urandom_range(112, 143));       // near threshold
        endcase
        pixels_to_send.push_back(g);
      end
      if (phase == 4) long_hold_armed = 1'b1;
      total += n;
      phase++;
      drain_block();
    end

    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
